/* rtl/core/q16dm_pkg.sv */
// ----------------------------------------------------------------------------
// q16dm_pkg: shared constants and types of the 16-QAM soft demapper
// Sample and soft-bit widths, unit level, rounding position, queue depth.
// ----------------------------------------------------------------------------
package q16dm_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int LLR_WIDTH    = 24;
  localparam int NVAR_WIDTH   = 16;
  localparam int NVAR_FRAC    = 8;
  localparam int OUT_FRAC     = 13;
  localparam int FRAC_BITS    = SAMPLE_WIDTH - 3;

  localparam longint INV_SQRT10_Q32 = 64'd1358187913;
  localparam int     U_SHIFT        = 32 - FRAC_BITS;
  localparam longint UNIT_LEVEL     =
    (INV_SQRT10_Q32 + (longint'(1) << (U_SHIFT - 1))) >> U_SHIFT;

  localparam int MAG_W     = SAMPLE_WIDTH;
  localparam int U_W       = FRAC_BITS;
  localparam int P1_W      = MAG_W + U_W;
  localparam int P2_W      = P1_W + NVAR_WIDTH;
  // distance differences carry a factor 4u, folded into the shift
  localparam int RND_SHIFT = 2 * FRAC_BITS + NVAR_FRAC - OUT_FRAC - 2;
  localparam int Q_W       = P2_W + 1 - RND_SHIFT;
  localparam int EXT_W     = (Q_W > LLR_WIDTH + 1) ? Q_W : LLR_WIDTH + 1;

  localparam int NUM_LANES    = 4;
  localparam int LANE_RE_SIGN = 0;
  localparam int LANE_IM_SIGN = 1;
  localparam int LANE_RE_LVL  = 2;
  localparam int LANE_IM_LVL  = 3;

  localparam int FIFO_DEPTH = 4;   // power of two
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [LLR_WIDTH-1:0]    llr_t;
  typedef logic        [MAG_W-1:0]        mag_t;
  typedef logic        [NVAR_WIDTH-1:0]   nvar_t;

  localparam nvar_t NVAR_RESET = nvar_t'(256);

  typedef struct packed {
    logic neg;
    mag_t mag;
  } lane_t;

  typedef lane_t [NUM_LANES-1:0] lane_vec_t;

  typedef struct packed {
    logic      valid;
    lane_vec_t item;
  } q_head_t;

endpackage

/* rtl/core/q16dm_in_if.sv */
// ----------------------------------------------------------------------------
// q16dm_in_if: symbol input channel
// One received symbol (I, Q) per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface q16dm_in_if;
  import q16dm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t in_phase;
  sample_t quadrature;

  modport source (output valid, output in_phase, output quadrature, input ready);
  modport sink   (input valid, input in_phase, input quadrature, output ready);
endinterface

/* rtl/core/q16dm_out_if.sv */
// ----------------------------------------------------------------------------
// q16dm_out_if: soft-bit output channel
// Four saturated soft bits per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface q16dm_out_if;
  import q16dm_pkg::*;

  logic valid;
  logic ready;
  llr_t llr_bit0;
  llr_t llr_bit1;
  llr_t llr_bit2;
  llr_t llr_bit3;

  modport source (output valid, output llr_bit0, output llr_bit1, output llr_bit2,
                  output llr_bit3, input ready);
  modport sink   (input valid, input llr_bit0, input llr_bit1, input llr_bit2,
                  input llr_bit3, output ready);
endinterface

/* rtl/core/q16dm_cfg_if.sv */
// ----------------------------------------------------------------------------
// q16dm_cfg_if: configuration write channel
// Carries the inverse noise variance, valid/ready handshake.
// ----------------------------------------------------------------------------
interface q16dm_cfg_if;
  import q16dm_pkg::*;

  logic  valid;
  logic  ready;
  nvar_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/qam16_soft_demapper.sv */
// ----------------------------------------------------------------------------
// qam16_soft_demapper: max-log soft demapper for Gray-coded 16-QAM
// One symbol in, four saturated soft bits out, scaled by inverse noise var.
//
// channel   port     dir  word
// symbols   in_bus   in   in_phase, quadrature (Q2.13)
// softbits  out_bus  out  llr_bit0..llr_bit3 (24 bit, sat.)
// config    cfg_bus  in   inverse noise variance (Q8.8)
//
// One word per clock while out_bus is not stalled; each result passes
// the intake register, queue, two multiplier stages and output register.
// Synchronous active-low reset empties the pipe, weight back to 1.0.
// Output stall freezes the back end; the 4-word queue and intake
// register absorb input, then in_bus.ready drops.
// ----------------------------------------------------------------------------
module qam16_soft_demapper (
  input  logic         clk,
  input  logic         rst_n,
  q16dm_in_if.sink     in_bus,
  q16dm_cfg_if.sink    cfg_bus,
  q16dm_out_if.source  out_bus
);
  import q16dm_pkg::*;

  logic      push_valid;
  logic      push_ready;
  lane_vec_t push_item;
  q_head_t   head;
  logic      pop;

  q16dm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  q16dm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  q16dm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .pop     (pop),
    .cfg_bus (cfg_bus),
    .out_bus (out_bus)
  );

endmodule

/* rtl/core/q16dm_front.sv */
// ----------------------------------------------------------------------------
// q16dm_front: symbol intake and region classification
// Folds each axis into sign and level lanes: negate flag plus a magnitude
// that the back end scales by the unit level and the noise weight.
// ----------------------------------------------------------------------------
module q16dm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  q16dm_in_if.sink             in_bus,
  output logic                 push_valid,
  output q16dm_pkg::lane_vec_t push_item,
  input  logic                 push_ready
);
  import q16dm_pkg::*;

  localparam mag_t U_MAG  = mag_t'(UNIT_LEVEL);
  localparam mag_t U2_MAG = mag_t'(2 * UNIT_LEVEL);

  logic      valid_r, valid_nxt;
  lane_vec_t item_r, item_nxt;
  logic      accept;

  assign in_bus.ready = !valid_r || push_ready;
  assign accept       = in_bus.valid && in_bus.ready;
  assign push_valid   = valid_r;
  assign push_item    = item_r;

  always_comb begin
    sample_t x;
    logic    neg;
    mag_t    a;
    item_nxt = item_r;
    for (int ax = 0; ax < 2; ax++) begin
      x   = (ax == 0) ? in_bus.in_phase : in_bus.quadrature;
      neg = x[SAMPLE_WIDTH-1];
      a   = neg ? mag_t'(-x) : mag_t'(x);
      // sign lane: 4u*a inside, 8u*(a-u) beyond the 2u boundary
      item_nxt[LANE_RE_SIGN + ax].neg = neg;
      item_nxt[LANE_RE_SIGN + ax].mag = (a < U2_MAG) ? a : mag_t'({a - U_MAG, 1'b0});
      // level lane: 4u*(2u-a)
      item_nxt[LANE_RE_LVL + ax].neg  = (a > U2_MAG);
      item_nxt[LANE_RE_LVL + ax].mag  = (a > U2_MAG) ? (a - U2_MAG) : (U2_MAG - a);
    end
  end

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

/* rtl/core/q16dm_fifo.sv */
// ----------------------------------------------------------------------------
// q16dm_fifo: word queue between front and back
// Small circular buffer; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module q16dm_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  input  q16dm_pkg::lane_vec_t push_item,
  output logic                 push_ready,
  output q16dm_pkg::q_head_t   head,
  input  logic                 pop
);
  import q16dm_pkg::*;

  lane_vec_t            mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   count_r, count_nxt;
  logic                 push;

  assign push_ready = (count_r != FIFO_CW'(FIFO_DEPTH));
  assign push       = push_valid && push_ready;
  assign head.valid = (count_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == FIFO_CW'(FIFO_DEPTH) && !pop) |=> count_r == FIFO_CW'(FIFO_DEPTH))
    else $error("queue lost a word while full");

endmodule

/* rtl/core/q16dm_back.sv */
// ----------------------------------------------------------------------------
// q16dm_back: scaling, rounding and saturation
// Three stages: times unit level, times noise weight, round and clip.
// Holds the inverse noise variance register.
// ----------------------------------------------------------------------------
module q16dm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  q16dm_pkg::q_head_t head,
  output logic               pop,
  q16dm_cfg_if.sink          cfg_bus,
  q16dm_out_if.source        out_bus
);
  import q16dm_pkg::*;

  localparam logic [P2_W:0]    RND_HALF = (P2_W + 1)'(1) << (RND_SHIFT - 1);
  localparam logic [EXT_W-1:0] POS_MAX  =
    EXT_W'((longint'(1) << (LLR_WIDTH - 1)) - 1);
  localparam logic [EXT_W-1:0] NEG_LIM  = EXT_W'(longint'(1) << (LLR_WIDTH - 1));
  localparam llr_t             LLR_MAX  = llr_t'(POS_MAX);
  localparam llr_t             LLR_MIN  = llr_t'(NEG_LIM);

  nvar_t                   nvar_r;
  logic                    en;

  logic                    s1_valid_r;
  logic [NUM_LANES-1:0]    s1_neg_r;
  logic [P1_W-1:0]         s1_prod_r [NUM_LANES];
  logic                    s2_valid_r;
  logic [NUM_LANES-1:0]    s2_neg_r;
  logic [P2_W-1:0]         s2_prod_r [NUM_LANES];
  logic                    out_valid_r;
  llr_t                    out_llr_r [NUM_LANES];
  llr_t                    out_llr_nxt [NUM_LANES];

  assign cfg_bus.ready = 1'b1;
  assign en            = !out_valid_r || out_bus.ready;
  assign pop           = en && head.valid;

  assign out_bus.valid    = out_valid_r;
  assign out_bus.llr_bit0 = out_llr_r[0];
  assign out_bus.llr_bit1 = out_llr_r[1];
  assign out_bus.llr_bit2 = out_llr_r[2];
  assign out_bus.llr_bit3 = out_llr_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nvar_r <= NVAR_RESET;
    end else if (cfg_bus.valid) begin
      nvar_r <= cfg_bus.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= head.valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_comb begin
    logic [P2_W:0]    sum;
    logic [EXT_W-1:0] q;
    for (int i = 0; i < NUM_LANES; i++) begin
      sum = {1'b0, s2_prod_r[i]} + RND_HALF;
      q   = EXT_W'(sum >> RND_SHIFT);
      if (s2_neg_r[i]) begin
        out_llr_nxt[i] = (q > NEG_LIM) ? LLR_MIN : llr_t'(-q[LLR_WIDTH-1:0]);
      end else begin
        out_llr_nxt[i] = (q > POS_MAX) ? LLR_MAX : llr_t'(q[LLR_WIDTH-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        s1_neg_r[i]  <= head.item[i].neg;
        s1_prod_r[i] <= P1_W'(head.item[i].mag) * P1_W'(UNIT_LEVEL);
        s2_neg_r[i]  <= s1_neg_r[i];
        s2_prod_r[i] <= P2_W'(s1_prod_r[i]) * P2_W'(nvar_r);
        out_llr_r[i] <= out_llr_nxt[i];
      end
    end
  end

  a_s1_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (head.valid && en) |=> s1_valid_r)
    else $error("popped word missing from first stage");

  a_s2_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && en) |=> s2_valid_r)
    else $error("word dropped between stages");

  a_sign_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && en) |=> (out_valid_r &&
      (!out_llr_r[LANE_RE_SIGN][LLR_WIDTH-1] || $past(s2_neg_r[LANE_RE_SIGN]))))
    else $error("negative soft bit from positive lane");

endmodule
